>>> rtl/read_symbol_statistics_defines.svh
// ---------------------------------------------------------------------------
// read symbol statistics assertion macros
// concurrent check helpers, empty in synthesis
// ---------------------------------------------------------------------------
`ifndef READ_SYMBOL_STATISTICS_DEFINES_SVH
`define READ_SYMBOL_STATISTICS_DEFINES_SVH

`ifndef SYNTHESIS
`define RSS_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("rss check failed: never condition");
`define RSS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rss check failed: same cycle implication");
`define RSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rss check failed: next cycle implication");
`else
`define RSS_ASSERT_NEVER(label, clk, rst, expr)
`define RSS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RSS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/rss_pkg.sv
// ---------------------------------------------------------------------------
// rss_pkg
// shared constants, command type and helpers of the symbol statistics block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rss_pkg;

  localparam int SYMBOLS    = 256;
  localparam int SYM_BITS   = $clog2(SYMBOLS);
  localparam int COUNT_BITS = 32;
  localparam int RUN_BITS   = 16;
  localparam int TAIL_BITS  = 16;
  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = $clog2(QDEPTH);

  localparam logic [SYM_BITS-1:0] N_SYMBOL = 8'h4E;

  localparam logic [1:0] FUNC_PAIR  = 2'd0;
  localparam logic [1:0] FUNC_EMPTY = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [RUN_BITS-1:0]   RUN_MAX   = '1;
  localparam logic [TAIL_BITS-1:0]  TAIL_MAX  = '1;

  typedef struct packed {
    logic                  is_read;
    logic                  seq_en;
    logic [SYM_BITS-1:0]   seq_addr;
    logic                  qual_en;
    logic [SYM_BITS-1:0]   qual_addr;
    logic                  tail_en;
    logic [SYM_BITS-1:0]   tail_addr;
    logic                  run_en;
    logic [SYM_BITS-1:0]   run_addr;
    logic [RUN_BITS-1:0]   run_len;
    logic [SYM_BITS-1:0]   index;
    logic [COUNT_BITS-1:0] record_count;
    logic [COUNT_BITS-1:0] total_symbols;
    logic [7:0]            qual_min;
    logic [7:0]            qual_max;
    logic [7:0]            n_qual_min;
    logic [7:0]            n_qual_max;
  } cmd_t;

  function automatic logic [COUNT_BITS-1:0] count_inc(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

>>> rtl/rss_hist_ram.sv
// ---------------------------------------------------------------------------
// rss_hist_ram
// one write, one registered read port store with per entry valid bits
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rss_hist_ram #(
  parameter int WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        re,
  input  logic [rss_pkg::SYM_BITS-1:0] raddr,
  output logic [WIDTH-1:0]            rdata,
  input  logic                        we,
  input  logic [rss_pkg::SYM_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]            wdata
);
  import rss_pkg::*;

  logic [WIDTH-1:0] mem [SYMBOLS];
  logic [SYMBOLS-1:0] vld;
  logic [WIDTH-1:0] rd_raw;
  logic rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_raw <= mem[raddr];
    end
  end

  // unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (re) begin
        rd_vld <= vld[raddr];
      end
    end
  end

  assign rdata = rd_vld ? rd_raw : '0;

endmodule

>>> rtl/rss_front.sv
// ---------------------------------------------------------------------------
// rss_front
// accepts items, tracks runs, tails, quality ranges and totals, issues store commands
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rss_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              func,
  input  logic [7:0]              seq_byte,
  input  logic [7:0]              qual_byte,
  input  logic                    last_of_record,
  input  logic [7:0]              index,
  input  logic [15:0]             min_tail,
  input  logic                    q_full,
  output logic                    q_push,
  output rss_pkg::cmd_t           q_cmd
);
  import rss_pkg::*;

  logic [COUNT_BITS-1:0] records_seen, records_seen_next;
  logic [COUNT_BITS-1:0] symbols_seen, symbols_seen_next;
  logic [7:0] qual_low, qual_low_next, qual_high, qual_high_next;
  logic [7:0] n_low, n_low_next, n_high, n_high_next;
  logic [SYM_BITS-1:0] run_symbol, run_symbol_next;
  logic [RUN_BITS-1:0] run_length, run_length_next;
  logic run_open, run_open_next;
  logic [7:0] tail_symbol, tail_symbol_next;
  logic [TAIL_BITS-1:0] tail_run, tail_run_next;

  logic accept, is_pair, is_empty, is_read, rec_end, same_run, close_prev, tail_cont;
  logic e_run_open;
  logic [SYM_BITS-1:0] e_run_sym;
  logic [RUN_BITS-1:0] e_run_len;
  logic [7:0] e_tail_sym;
  logic [TAIL_BITS-1:0] e_tail_run;
  logic none_seen;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    is_pair  = (func == FUNC_PAIR);
    is_empty = (func == FUNC_EMPTY);
    is_read  = (func == FUNC_READ);
    rec_end  = (is_pair && last_of_record) || is_empty;
    same_run = run_open && (seq_byte == run_symbol);
    close_prev = is_pair && !same_run && run_open && (run_length != '0);
    tail_cont  = (tail_run != '0) && (qual_byte == tail_symbol);

    // run and tail state as seen by a record end in this item
    if (is_pair) begin
      e_run_open = 1'b1;
      e_run_sym  = seq_byte;
      e_run_len  = same_run ? ((run_length == RUN_MAX) ? run_length : run_length + 1'b1)
                            : '0;
      e_tail_sym = qual_byte;
      e_tail_run = tail_cont ? ((tail_run == TAIL_MAX) ? tail_run : tail_run + 1'b1)
                             : TAIL_BITS'(1);
    end else begin
      e_run_open = run_open;
      e_run_sym  = run_symbol;
      e_run_len  = run_length;
      e_tail_sym = tail_symbol;
      e_tail_run = tail_run;
    end

    none_seen = qual_low > qual_high;

    q_cmd = '0;
    q_cmd.is_read   = is_read;
    q_cmd.seq_en    = is_pair;
    q_cmd.seq_addr  = seq_byte;
    q_cmd.qual_en   = is_pair;
    q_cmd.qual_addr = qual_byte;
    q_cmd.tail_addr = e_tail_sym;
    q_cmd.tail_en   = rec_end && (e_tail_run != '0) && (e_tail_run >= min_tail)
                      && (e_tail_sym != '0);
    if (close_prev) begin
      q_cmd.run_en   = 1'b1;
      q_cmd.run_addr = run_symbol;
      q_cmd.run_len  = run_length;
    end else begin
      q_cmd.run_en   = rec_end && e_run_open && (e_run_len != '0);
      q_cmd.run_addr = e_run_sym;
      q_cmd.run_len  = e_run_len;
    end
    q_cmd.index         = index;
    q_cmd.record_count  = records_seen;
    q_cmd.total_symbols = symbols_seen;
    q_cmd.qual_min      = none_seen ? 8'd0 : qual_low;
    q_cmd.qual_max      = none_seen ? 8'd0 : qual_high;
    q_cmd.n_qual_min    = n_low;
    q_cmd.n_qual_max    = n_high;

    q_push = accept && (is_pair || is_empty || is_read);

    records_seen_next = records_seen;
    symbols_seen_next = symbols_seen;
    qual_low_next  = qual_low;
    qual_high_next = qual_high;
    n_low_next     = n_low;
    n_high_next    = n_high;
    run_symbol_next  = run_symbol;
    run_length_next  = run_length;
    run_open_next    = run_open;
    tail_symbol_next = tail_symbol;
    tail_run_next    = tail_run;

    if (accept && is_pair) begin
      symbols_seen_next = count_inc(symbols_seen);
      if (qual_byte < qual_low)  qual_low_next  = qual_byte;
      if (qual_byte > qual_high) qual_high_next = qual_byte;
      if (seq_byte == N_SYMBOL) begin
        if (qual_byte < n_low)  n_low_next  = qual_byte;
        if (qual_byte > n_high) n_high_next = qual_byte;
      end
      run_symbol_next  = e_run_sym;
      run_length_next  = e_run_len;
      run_open_next    = 1'b1;
      tail_symbol_next = e_tail_sym;
      tail_run_next    = e_tail_run;
    end
    if (accept && rec_end) begin
      records_seen_next = count_inc(records_seen);
      run_symbol_next  = '0;
      run_length_next  = '0;
      run_open_next    = 1'b0;
      tail_symbol_next = '0;
      tail_run_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      records_seen <= '0;
      symbols_seen <= '0;
      qual_low  <= 8'd255;
      qual_high <= 8'd0;
      n_low     <= 8'd255;
      n_high    <= 8'd0;
      run_symbol  <= '0;
      run_length  <= '0;
      run_open    <= 1'b0;
      tail_symbol <= '0;
      tail_run    <= '0;
    end else begin
      records_seen <= records_seen_next;
      symbols_seen <= symbols_seen_next;
      qual_low  <= qual_low_next;
      qual_high <= qual_high_next;
      n_low     <= n_low_next;
      n_high    <= n_high_next;
      run_symbol  <= run_symbol_next;
      run_length  <= run_length_next;
      run_open    <= run_open_next;
      tail_symbol <= tail_symbol_next;
      tail_run    <= tail_run_next;
    end
  end

endmodule

>>> rtl/rss_queue.sv
// ---------------------------------------------------------------------------
// rss_queue
// short command queue between front and back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "read_symbol_statistics_defines.svh"

module rss_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rss_pkg::cmd_t push_cmd,
  input  logic          pop,
  output rss_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);
  import rss_pkg::*;

  cmd_t slots [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (QPTR_BITS+1)'(QDEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `RSS_ASSERT_IMPLY(a_no_push_full, clk, rst, push, !full)
  `RSS_ASSERT_IMPLY(a_no_pop_empty, clk, rst, pop, !empty)
  `RSS_ASSERT_NEVER(a_count_range, clk, rst, count > (QPTR_BITS+1)'(QDEPTH))
  `RSS_ASSERT_NEXT(a_count_grows, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule

>>> rtl/rss_back.sv
// ---------------------------------------------------------------------------
// rss_back
// read-modify-write of the four histogram stores and the result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rss_back (
  input  logic                  clk,
  input  logic                  rst,
  input  rss_pkg::cmd_t         head,
  input  logic                  q_empty,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           seq_count_at,
  output logic [31:0]           qual_count_at,
  output logic [31:0]           tail_count_at,
  output logic [15:0]           maxrun_at,
  output logic [31:0]           record_count,
  output logic [31:0]           total_symbols,
  output logic [7:0]            qual_min,
  output logic [7:0]            qual_max,
  output logic [7:0]            n_qual_min,
  output logic [7:0]            n_qual_max
);
  import rss_pkg::*;

  logic en;
  logic x_valid;
  cmd_t x_cmd;

  logic [SYM_BITS-1:0] seq_ra, qual_ra, tail_ra, run_ra;
  logic [SYM_BITS-1:0] seq_xa, qual_xa, tail_xa, run_xa;
  logic [COUNT_BITS-1:0] seq_rd, qual_rd, tail_rd;
  logic [RUN_BITS-1:0] run_rd;
  logic [COUNT_BITS-1:0] seq_cur, qual_cur, tail_cur;
  logic [RUN_BITS-1:0] run_cur;
  logic seq_we, qual_we, tail_we, run_we;

  // last write of each store, for a back to back hit
  logic seq_fv, qual_fv, tail_fv, run_fv;
  logic [SYM_BITS-1:0] seq_fa, qual_fa, tail_fa, run_fa;
  logic [COUNT_BITS-1:0] seq_fd, qual_fd, tail_fd;
  logic [RUN_BITS-1:0] run_fd;

  assign en    = !out_valid || !out_stall;
  assign q_pop = en && !q_empty;

  always_comb begin
    seq_ra  = head.is_read ? head.index : head.seq_addr;
    qual_ra = head.is_read ? head.index : head.qual_addr;
    tail_ra = head.is_read ? head.index : head.tail_addr;
    run_ra  = head.is_read ? head.index : head.run_addr;
    seq_xa  = x_cmd.is_read ? x_cmd.index : x_cmd.seq_addr;
    qual_xa = x_cmd.is_read ? x_cmd.index : x_cmd.qual_addr;
    tail_xa = x_cmd.is_read ? x_cmd.index : x_cmd.tail_addr;
    run_xa  = x_cmd.is_read ? x_cmd.index : x_cmd.run_addr;

    seq_cur  = (seq_fv && seq_fa == seq_xa) ? seq_fd : seq_rd;
    qual_cur = (qual_fv && qual_fa == qual_xa) ? qual_fd : qual_rd;
    tail_cur = (tail_fv && tail_fa == tail_xa) ? tail_fd : tail_rd;
    run_cur  = (run_fv && run_fa == run_xa) ? run_fd : run_rd;

    seq_we  = en && x_valid && !x_cmd.is_read && x_cmd.seq_en;
    qual_we = en && x_valid && !x_cmd.is_read && x_cmd.qual_en;
    tail_we = en && x_valid && !x_cmd.is_read && x_cmd.tail_en;
    run_we  = en && x_valid && !x_cmd.is_read && x_cmd.run_en && (x_cmd.run_len > run_cur);
  end

  rss_hist_ram #(.WIDTH(COUNT_BITS)) u_seq_ram (
    .clk(clk), .rst(rst), .re(en), .raddr(seq_ra), .rdata(seq_rd),
    .we(seq_we), .waddr(seq_xa), .wdata(count_inc(seq_cur))
  );
  rss_hist_ram #(.WIDTH(COUNT_BITS)) u_qual_ram (
    .clk(clk), .rst(rst), .re(en), .raddr(qual_ra), .rdata(qual_rd),
    .we(qual_we), .waddr(qual_xa), .wdata(count_inc(qual_cur))
  );
  rss_hist_ram #(.WIDTH(COUNT_BITS)) u_tail_ram (
    .clk(clk), .rst(rst), .re(en), .raddr(tail_ra), .rdata(tail_rd),
    .we(tail_we), .waddr(tail_xa), .wdata(count_inc(tail_cur))
  );
  rss_hist_ram #(.WIDTH(RUN_BITS)) u_run_ram (
    .clk(clk), .rst(rst), .re(en), .raddr(run_ra), .rdata(run_rd),
    .we(run_we), .waddr(run_xa), .wdata(x_cmd.run_len)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      x_cmd <= head;
    end
    if (seq_we)  begin seq_fa  <= seq_xa;  seq_fd  <= count_inc(seq_cur);  end
    if (qual_we) begin qual_fa <= qual_xa; qual_fd <= count_inc(qual_cur); end
    if (tail_we) begin tail_fa <= tail_xa; tail_fd <= count_inc(tail_cur); end
    if (run_we)  begin run_fa  <= run_xa;  run_fd  <= x_cmd.run_len;       end
    if (en && x_valid && x_cmd.is_read) begin
      seq_count_at  <= seq_cur;
      qual_count_at <= qual_cur;
      tail_count_at <= tail_cur;
      maxrun_at     <= run_cur;
      record_count  <= x_cmd.record_count;
      total_symbols <= x_cmd.total_symbols;
      qual_min      <= x_cmd.qual_min;
      qual_max      <= x_cmd.qual_max;
      n_qual_min    <= x_cmd.n_qual_min;
      n_qual_max    <= x_cmd.n_qual_max;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid   <= 1'b0;
      out_valid <= 1'b0;
      seq_fv  <= 1'b0;
      qual_fv <= 1'b0;
      tail_fv <= 1'b0;
      run_fv  <= 1'b0;
    end else begin
      if (en) begin
        x_valid   <= !q_empty;
        out_valid <= x_valid && x_cmd.is_read;
      end
      if (seq_we)  seq_fv  <= 1'b1;
      if (qual_we) qual_fv <= 1'b1;
      if (tail_we) tail_fv <= 1'b1;
      if (run_we)  run_fv  <= 1'b1;
    end
  end

endmodule

>>> rtl/read_symbol_statistics.sv
// ---------------------------------------------------------------------------
// read_symbol_statistics
// per byte histograms, longest runs and quality ranges of sequencing reads
// ---------------------------------------------------------------------------
// one item is taken per cycle, symbol pairs, empty records and read items
// alike, as long as no result is held by out_stall; a read item passes the
// command queue and the x_cmd register, and its result is offered from the
// result register. the rate is set by the read-modify-write loop of the
// four 256 entry stores, which runs once per cycle with a one deep bypass
// of the last write. a four entry command queue lets the input side keep
// taking items while a result is held by out_stall, until the queue is
// full. all stores read as zero right after reset; no clearing pass is
// needed. min_tail is written through the cfg channel, always ready.
`timescale 1ns / 1ps

module read_symbol_statistics (
  input  logic        clk,
  input  logic        rst,
  // config channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // input item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [7:0]  seq_byte,
  input  logic [7:0]  qual_byte,
  input  logic        last_of_record,
  input  logic [7:0]  index,
  // result item channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] seq_count_at,
  output logic [31:0] qual_count_at,
  output logic [31:0] tail_count_at,
  output logic [15:0] maxrun_at,
  output logic [31:0] record_count,
  output logic [31:0] total_symbols,
  output logic [7:0]  qual_min,
  output logic [7:0]  qual_max,
  output logic [7:0]  n_qual_min,
  output logic [7:0]  n_qual_max
);
  import rss_pkg::*;

  logic [15:0] min_tail;
  logic q_push, q_pop, q_empty, q_full;
  cmd_t q_cmd, q_head;

  // minimum tail length register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      min_tail <= 16'd4;
    end else if (cfg_valid && cfg_ready) begin
      min_tail <= cfg_data;
    end
  end

  // front: run and tail tracking, quality ranges, totals, command build
  rss_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .seq_byte(seq_byte), .qual_byte(qual_byte),
    .last_of_record(last_of_record), .index(index),
    .min_tail(min_tail),
    .q_full(q_full), .q_push(q_push), .q_cmd(q_cmd)
  );

  // decoupling queue
  rss_queue u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .push_cmd(q_cmd),
    .pop(q_pop), .head(q_head),
    .empty(q_empty), .full(q_full)
  );

  // back: histogram stores and result register
  rss_back u_back (
    .clk(clk), .rst(rst),
    .head(q_head), .q_empty(q_empty), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .seq_count_at(seq_count_at), .qual_count_at(qual_count_at),
    .tail_count_at(tail_count_at), .maxrun_at(maxrun_at),
    .record_count(record_count), .total_symbols(total_symbols),
    .qual_min(qual_min), .qual_max(qual_max),
    .n_qual_min(n_qual_min), .n_qual_max(n_qual_max)
  );

endmodule
